FILE: rtl/bba_pkg.sv
// Package for the bitmap block allocator.
// Field widths, status codes and the shared find-first-set helper.
// No dependencies.
package bba_pkg;

  // Field widths
  localparam int IDX_W  = 10;   // block index
  localparam int CNT_W  = 11;   // block counts and the block-count register
  localparam int STAT_W = 2;    // status code

  // Bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;    // log2 of WORD_W

  // Highest index span an IDX_W index can address
  localparam int IDX_SPAN = 1024;

  // Reset value of the block-count register
  localparam logic [CNT_W-1:0] BLOCKS_RST = 11'd1024;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADREL = 2'd2;

  // Lowest set bit of a word: {found, bit position}
  function automatic logic [BIT_W:0] ffs_word(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/bba_req_if.sv
// Request channel of the bitmap block allocator: valid, ready and payload.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [bba_pkg::IDX_W-1:0]  target_block;

  modport source (output valid, mode, target_block, input ready);
  modport sink   (input valid, mode, target_block, output ready);
endinterface

FILE: rtl/bba_rsp_if.sv
// Response channel of the bitmap block allocator: valid, ready and payload.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::IDX_W-1:0]   granted_index;
  logic [bba_pkg::STAT_W-1:0]  status;
  logic [bba_pkg::CNT_W-1:0]   used_blocks;
  logic [bba_pkg::CNT_W-1:0]   free_blocks;

  modport source (output valid, granted_index, status, used_blocks, free_blocks,
                  input ready);
  modport sink   (input valid, granted_index, status, used_blocks, free_blocks,
                  output ready);
endinterface

FILE: rtl/bba_cfg_if.sv
// Configuration write channel of the bitmap block allocator.
// Depends on bba_pkg for the register width.
interface bba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::CNT_W-1:0]  blocks_in_use;

  modport source (output valid, blocks_in_use, input ready);
  modport sink   (input valid, blocks_in_use, output ready);
endinterface

FILE: rtl/bitmap_block_allocator.sv
// Bitmap first-fit block allocator, top level.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bba_cfg_if.
//
//  channel | dir | beat contents
//  req_i   | in  | mode, target_block
//  rsp_o   | out | granted_index, status, used_blocks, free_blocks
//  cfg_i   | in  | blocks_in_use (always ready)
//
// A request steps from accept (word read issued) to evaluate (bitmap word
// updated) to done (result register loaded) before the next accept; the
// result beat shows in the cycle after done. The single bitmap memory port
// and the shared find-first-set unit make these steps sequential.
// Reset clears the used-bit store at once through per-word valid flags.
// A stalled result holds in the output register; a new request is taken
// meanwhile and waits in done until the register frees up.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o,
  bba_cfg_if.sink   cfg_i
);

  localparam int IDX_W  = bba_pkg::IDX_W;
  localparam int CNT_W  = bba_pkg::CNT_W;
  localparam int STAT_W = bba_pkg::STAT_W;
  localparam int WORD_W = bba_pkg::WORD_W;
  localparam int BIT_W  = bba_pkg::BIT_W;

  // Stored blocks: no index beyond the index span is ever reachable
  localparam int DEPTH = (NUM_BLOCKS < bba_pkg::IDX_SPAN) ? NUM_BLOCKS : bba_pkg::IDX_SPAN;
  localparam int NW    = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int WW    = (NW > 1) ? $clog2(NW) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  granted;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } res_t;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   blocks_q;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [NW-1:0]      wvalid_q;
  logic [NW-1:0]      full_q;
  logic               rvalid_q;
  logic [WORD_W-1:0]  rdata_q;
  logic [WORD_W-1:0]  mem_q [NW];

  // Per-request registers
  logic               mode_q;
  logic [BIT_W-1:0]   bit_q;
  logic [WW-1:0]      word_q;
  logic               inrange_q;
  logic               partial_q;
  logic               nocand_q;

  res_t               res_q, res_d;
  res_t               out_q;
  logic               out_valid_q;

  logic               req_fire, rsp_fire, cfg_fire;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   lim_words;
  logic [WORD_W-1:0]  cand;
  logic [WORD_W-1:0]  enc_in;
  logic [BIT_W:0]     enc;
  logic               enc_found;
  logic [BIT_W-1:0]   enc_idx;
  logic [WW-1:0]      rd_addr;
  logic               inrange;
  logic [WORD_W-1:0]  word_eff, lowmask, masked, wr_data;
  logic               alloc_ok, rel_ok, wr_en, out_free;
  logic [CNT_W:0]     sum_chk;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Effective limit
  assign lim = (blocks_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : blocks_q;
  assign lim_words = lim >> BIT_W;

  // Candidate words: fully in range and not full
  always_comb begin
    cand = '0;
    for (int w = 0; w < NW; w++) begin
      cand[w] = !full_q[w] && (CNT_W'(w) < lim_words);
    end
  end

  // Current word with a never-written word reading as all free
  assign word_eff = rvalid_q ? rdata_q : '0;
  assign lowmask  = (WORD_W'(1) << lim[BIT_W-1:0]) - WORD_W'(1);
  assign masked   = partial_q ? (word_eff | ~lowmask) : word_eff;

  // Shared find-first-set: word search when idle, bit search in evaluate
  assign enc_in    = (state_q == S_IDLE) ? cand : ~masked;
  assign enc       = bba_pkg::ffs_word(enc_in);
  assign enc_found = enc[BIT_W];
  assign enc_idx   = enc[BIT_W-1:0];

  // Read address at accept
  assign inrange = ({1'b0, req_i.target_block} < lim);
  always_comb begin
    rd_addr = '0;
    if (!req_i.mode) begin
      if (enc_found) begin
        rd_addr = enc_idx[WW-1:0];
      end else if (lim[BIT_W-1:0] != '0) begin
        rd_addr = lim[BIT_W +: WW];
      end
    end else if (inrange) begin
      rd_addr = req_i.target_block[BIT_W +: WW];
    end
  end

  // Evaluate: decision, word update and counts
  assign alloc_ok = !mode_q && !nocand_q && enc_found;
  assign rel_ok   = mode_q && inrange_q && word_eff[bit_q];
  assign wr_en    = (state_q == S_EVAL) && (alloc_ok || rel_ok);
  assign wr_data  = alloc_ok ? (word_eff | (WORD_W'(1) << enc_idx))
                             : (word_eff & ~(WORD_W'(1) << bit_q));

  always_comb begin
    used_d = used_q;
    if (alloc_ok) begin
      used_d = used_q + CNT_W'(1);
    end else if (rel_ok && used_q != '0) begin
      used_d = used_q - CNT_W'(1);
    end
  end

  always_comb begin
    res_d.granted = alloc_ok ? IDX_W'({word_q, enc_idx}) : '0;
    if (mode_q) begin
      res_d.status = rel_ok ? bba_pkg::ST_OK : bba_pkg::ST_BADREL;
    end else begin
      res_d.status = alloc_ok ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
    end
    res_d.used = used_d;
    res_d.free = (lim > used_d) ? (lim - used_d) : '0;
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = S_EVAL;
      end
      S_EVAL: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blocks_q    <= bba_pkg::BLOCKS_RST;
      used_q      <= '0;
      wvalid_q    <= '0;
      full_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) blocks_q <= cfg_i.blocks_in_use;
      if (req_fire) rvalid_q <= wvalid_q[rd_addr];
      if (state_q == S_EVAL) used_q <= used_d;
      if (wr_en) begin
        wvalid_q[word_q] <= 1'b1;
        full_q[word_q]   <= &wr_data;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Bitmap memory
  always_ff @(posedge clk_i) begin
    if (req_fire) rdata_q <= mem_q[rd_addr];
    if (wr_en) mem_q[word_q] <= wr_data;
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q    <= req_i.mode;
      bit_q     <= req_i.target_block[BIT_W-1:0];
      word_q    <= rd_addr;
      inrange_q <= inrange;
      partial_q <= !enc_found;
      nocand_q  <= !enc_found && (lim[BIT_W-1:0] == '0);
    end
    if (state_q == S_EVAL) res_q <= res_d;
    if (state_q == S_DONE && out_free) out_q <= res_q;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_index = out_q.granted;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.used_blocks   = out_q.used;
  assign rsp_o.free_blocks   = out_q.free;

  assign sum_chk = {1'b0, rsp_o.used_blocks} + {1'b0, rsp_o.free_blocks};

  // Checks
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_EVAL)
    else $error("accepted request did not move to evaluate");

  a_word_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && !mode_q && !nocand_q && !partial_q) |-> enc_found)
    else $error("summary picked a word with no free bit");

  a_full_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q & ~wvalid_q) == '0)
    else $error("full flag set on a never-written word");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(DEPTH))
    else $error("used count above stored blocks");

  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.free_blocks != '0) |-> sum_chk == {1'b0, lim})
    else $error("used plus free differs from limit");

endmodule
